// ----- src/mpu_pkg.sv -----
// Shared types and constants for the modular power unit.
package mpu_pkg;

  // Field widths.
  localparam int MOD_W = 31;
  localparam int EXP_W = 32;
  localparam int EXP_IN_W = 32;

  // Step counters for the bit-serial multiplier and the exponent scan.
  localparam int MUL_CNT_W = $clog2(MOD_W);
  localparam int EXP_CNT_W = $clog2(EXP_W);

  // Modulus after reset.
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // Fermat inverse uses the exponent modulus minus this offset.
  localparam logic [MOD_W-1:0] FERMAT_OFS = MOD_W'(2);

  // Action codes.
  localparam logic ACT_POWER = 1'b0;
  localparam logic ACT_INVERSE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } mpu_state_t;

  // Request to the serial modular multiplier.
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] multiplier;
    logic [MOD_W-1:0] multiplicand;
  } mpu_mul_req_t;

  // Response from the serial modular multiplier.
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] product;
  } mpu_mul_rsp_t;

endpackage

// ----- src/modular_power_unit_core.sv -----
// Top level of the modular power unit: sequencer and exponent scan.
//
// Computes base to the power exponent modulo the configured modulus by
// left-to-right binary square-and-multiply; action 1 uses the exponent
// modulus minus two, which gives the modular inverse when the modulus is
// prime. All products go through one bit-serial modular multiplier that
// consumes the 31 multiplier bits one at a time after launch. An item
// costs one product to reduce the base, one squaring for each of the 32
// exponent bits and one multiply for each set exponent bit. A modulus
// below two returns 0 without using the multiplier. One item is processed
// at a time; a new item may be transferred while the previous result still
// waits in the output register. The modulus may only be written while the
// unit is idle.
module modular_power_unit_core (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration.
  input  logic                           cfg_wr_en,
  input  logic [mpu_pkg::MOD_W-1:0]      cfg_wr_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [mpu_pkg::MOD_W-1:0]      base,
  input  logic [mpu_pkg::EXP_IN_W-1:0]   exponent,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mpu_pkg::MOD_W-1:0]      result
);

  mpu_pkg::mpu_state_t state;
  mpu_pkg::mpu_state_t state_next;

  logic [mpu_pkg::MOD_W-1:0]     modulus;
  logic [mpu_pkg::MOD_W-1:0]     base_in;
  logic [mpu_pkg::MOD_W-1:0]     base_red;
  logic [mpu_pkg::MOD_W-1:0]     acc;
  logic [mpu_pkg::EXP_W-1:0]     exp_sr;
  logic [mpu_pkg::EXP_CNT_W-1:0] exp_cnt;

  mpu_pkg::mpu_mul_req_t mul_req;
  mpu_pkg::mpu_mul_rsp_t mul_rsp;

  logic                      in_xfer;
  logic                      out_free;
  logic                      mod_small;
  logic [mpu_pkg::MOD_W-1:0] inv_exp;
  logic [63:0]               exp_wide;
  logic                      last_bit;

  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mod_small = (modulus < mpu_pkg::MOD_W'(2));
  assign inv_exp   = modulus - mpu_pkg::FERMAT_OFS;
  assign last_bit  = (exp_cnt == '0);

  // Exponent for the item, masked to the scanned width.
  always_comb begin
    if (action == mpu_pkg::ACT_INVERSE) begin
      exp_wide = {{(64 - mpu_pkg::MOD_W){1'b0}}, inv_exp};
    end else begin
      exp_wide = {{(64 - mpu_pkg::EXP_IN_W){1'b0}}, exponent};
    end
  end

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mpu_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  // Shared serial multiplier.
  mpu_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .modulus (modulus),
    .rsp     (mul_rsp)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mpu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mod_small ? mpu_pkg::ST_OUT : mpu_pkg::ST_RED_GO;
        end
      end
      mpu_pkg::ST_RED_GO: state_next = mpu_pkg::ST_RED_WAIT;
      mpu_pkg::ST_RED_WAIT: begin
        if (mul_rsp.done) begin
          state_next = mpu_pkg::ST_SQR_GO;
        end
      end
      mpu_pkg::ST_SQR_GO: state_next = mpu_pkg::ST_SQR_WAIT;
      mpu_pkg::ST_SQR_WAIT: begin
        if (mul_rsp.done) begin
          if (exp_sr[mpu_pkg::EXP_W-1]) begin
            state_next = mpu_pkg::ST_MUL_GO;
          end else if (last_bit) begin
            state_next = mpu_pkg::ST_OUT;
          end else begin
            state_next = mpu_pkg::ST_SQR_GO;
          end
        end
      end
      mpu_pkg::ST_MUL_GO: state_next = mpu_pkg::ST_MUL_WAIT;
      mpu_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          state_next = last_bit ? mpu_pkg::ST_OUT : mpu_pkg::ST_SQR_GO;
        end
      end
      mpu_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = mpu_pkg::ST_IDLE;
        end
      end
      default: state_next = mpu_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input stall and multiplier launches. The base
  // is reduced as base times one, so it need not be below the modulus.
  always_comb begin
    in_stall             = (state != mpu_pkg::ST_IDLE);
    mul_req.start        = 1'b0;
    mul_req.multiplier   = acc;
    mul_req.multiplicand = acc;
    case (state)
      mpu_pkg::ST_RED_GO: begin
        mul_req.start        = 1'b1;
        mul_req.multiplier   = base_in;
        mul_req.multiplicand = mpu_pkg::MOD_W'(1);
      end
      mpu_pkg::ST_SQR_GO: begin
        mul_req.start = 1'b1;
      end
      mpu_pkg::ST_MUL_GO: begin
        mul_req.start        = 1'b1;
        mul_req.multiplicand = base_red;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // Datapath: operands, running value and exponent shift register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_in <= base;
      exp_sr  <= exp_wide[mpu_pkg::EXP_W-1:0];
      exp_cnt <= mpu_pkg::EXP_CNT_W'(mpu_pkg::EXP_W - 1);
      acc     <= '0;
    end else if (mul_rsp.done) begin
      case (state)
        mpu_pkg::ST_RED_WAIT: begin
          base_red <= mul_rsp.product;
          acc      <= mpu_pkg::MOD_W'(1);
        end
        mpu_pkg::ST_SQR_WAIT: begin
          acc <= mul_rsp.product;
          if (!exp_sr[mpu_pkg::EXP_W-1]) begin
            exp_sr  <= {exp_sr[mpu_pkg::EXP_W-2:0], 1'b0};
            exp_cnt <= exp_cnt - 1'b1;
          end
        end
        mpu_pkg::ST_MUL_WAIT: begin
          acc     <= mul_rsp.product;
          exp_sr  <= {exp_sr[mpu_pkg::EXP_W-2:0], 1'b0};
          exp_cnt <= exp_cnt - 1'b1;
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mpu_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mpu_pkg::ST_OUT && out_free) begin
      result <= acc;
    end
  end

endmodule

// ----- src/mpu_mulmod.sv -----
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
module mpu_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  mpu_pkg::mpu_mul_req_t       req,
  input  logic [mpu_pkg::MOD_W-1:0]   modulus,
  output mpu_pkg::mpu_mul_rsp_t       rsp
);

  logic [mpu_pkg::MOD_W-1:0]     acc;
  logic [mpu_pkg::MOD_W-1:0]     mplier;
  logic [mpu_pkg::MOD_W-1:0]     mcand;
  logic [mpu_pkg::MUL_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;

  logic [mpu_pkg::MOD_W+1:0] sum;
  logic [mpu_pkg::MOD_W+1:0] mod1;
  logic [mpu_pkg::MOD_W+1:0] mod2;
  logic [mpu_pkg::MOD_W+1:0] sub1;
  logic [mpu_pkg::MOD_W+1:0] sub2;
  logic [mpu_pkg::MOD_W-1:0] acc_next;

  // One step: double the accumulator, add the multiplicand when the current
  // multiplier bit is set, then fold back below the modulus. Both the
  // accumulator and the multiplicand are below the modulus, so the sum is
  // below three times the modulus and at most two subtractions are needed.
  always_comb begin
    sum = {1'b0, acc, 1'b0}
        + {2'b00, (mplier[mpu_pkg::MOD_W-1] ? mcand : '0)};
    mod1 = {2'b00, modulus};
    mod2 = {1'b0, modulus, 1'b0};
    sub1 = sum - mod1;
    sub2 = sum - mod2;
    if (sum >= mod2) begin
      acc_next = sub2[mpu_pkg::MOD_W-1:0];
    end else if (sum >= mod1) begin
      acc_next = sub1[mpu_pkg::MOD_W-1:0];
    end else begin
      acc_next = sum[mpu_pkg::MOD_W-1:0];
    end
  end

  // Control: a start loads the operands, then one bit is consumed per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= mpu_pkg::MUL_CNT_W'(mpu_pkg::MOD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mplier <= req.multiplier;
      mcand  <= req.multiplicand;
    end else if (busy) begin
      acc    <= acc_next;
      mplier <= {mplier[mpu_pkg::MOD_W-2:0], 1'b0};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ----- dv/mpu_checker.sv -----
`timescale 1ns / 100ps
// Checker for the modular power unit: predicts each power and compares it with the result port.
module mpu_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mpu_pkg::MOD_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         action,
  input  logic [mpu_pkg::MOD_W-1:0]    base,
  input  logic [mpu_pkg::EXP_IN_W-1:0] exponent,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [mpu_pkg::MOD_W-1:0]    result,
  output int                           fail_count,
  output int                           pending
);

  logic [mpu_pkg::MOD_W-1:0] modulus_q;
  logic [mpu_pkg::MOD_W-1:0] powers_due[$];
  int                        mismatches = 0;
  int                        due_count = 0;

  assign fail_count = mismatches;
  assign pending    = due_count;

  // Left-to-right square-and-multiply over all exponent bits; products fit in 62 bits.
  function automatic logic [mpu_pkg::MOD_W-1:0] modpow(
    input logic                         act,
    input logic [mpu_pkg::MOD_W-1:0]    b,
    input logic [mpu_pkg::EXP_IN_W-1:0] e,
    input logic [mpu_pkg::MOD_W-1:0]    m
  );
    logic [63:0]               mm;
    logic [63:0]               bb;
    logic [63:0]               acc;
    logic [mpu_pkg::EXP_W-1:0] ee;
    if (m < 2) return '0;
    mm  = 64'(m);
    ee  = (act == mpu_pkg::ACT_INVERSE) ? mpu_pkg::EXP_W'(m - mpu_pkg::FERMAT_OFS)
                                        : mpu_pkg::EXP_W'(e);
    bb  = 64'(b) % mm;
    acc = 64'd1;
    for (int i = mpu_pkg::EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (ee[i]) acc = (acc * bb) % mm;
    end
    return acc[mpu_pkg::MOD_W-1:0];
  endfunction

  // Sample at the falling edge: a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    logic [mpu_pkg::MOD_W-1:0] want;
    if (rst) begin
      modulus_q <= mpu_pkg::MOD_RESET;
      powers_due.delete();
    end else begin
      if (cfg_wr_en) modulus_q <= cfg_wr_data;
      if (in_valid && !in_stall) powers_due.push_back(modpow(action, base, exponent, modulus_q));
      if (out_valid && !out_stall) begin
        if (powers_due.size() == 0) begin
          $error("result: expected none, actual %0d", result);
          mismatches++;
        end else begin
          want = powers_due.pop_front();
          if (result !== want) begin
            $error("result: expected %0d, actual %0d", want, result);
            mismatches++;
          end
        end
      end
    end
    due_count = powers_due.size();
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the modular power unit.
module tb;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int LONG_HOLD      = 6000;
  localparam int DRAIN_CYCLES   = 2400;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 119;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [mpu_pkg::MOD_W-1:0]    cfg_wr_data;
  logic                         in_valid;
  logic                         in_stall;
  logic                         action;
  logic [mpu_pkg::MOD_W-1:0]    base;
  logic [mpu_pkg::EXP_IN_W-1:0] exponent;
  logic                         out_valid;
  logic                         out_stall;
  logic [mpu_pkg::MOD_W-1:0]    result;

  int                        fail_count;
  int                        pending;
  int                        quiet_cycles = 0;
  logic                      gaps_on;
  logic                      stalls_on;
  logic                      long_hold_req;
  logic [mpu_pkg::MOD_W-1:0] cur_mod;

  modular_power_unit_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .base        (base),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  mpu_checker watch (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .base        (base),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, maybe after an idle burst, and return at the edge of its transfer.
  task automatic offer(input logic act, input logic [mpu_pkg::MOD_W-1:0] b,
                       input logic [mpu_pkg::EXP_IN_W-1:0] e);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    base     <= b;
    exponent <= e;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid right at the edge of the last transfer.
  task automatic hold_inputs();
    in_valid <= 1'b0;
  endtask

  // Write the modulus once every result is back and the unit is idle.
  task automatic load_modulus(input logic [mpu_pkg::MOD_W-1:0] m);
    wait (pending == 0);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mod = m;
  endtask

  // Random item with bases and exponents biased toward edge values.
  task automatic offer_random();
    logic                         act;
    logic [mpu_pkg::MOD_W-1:0]    b;
    logic [mpu_pkg::EXP_IN_W-1:0] e;
    logic [63:0]                  mult;
    act = ($urandom_range(0, 2) == 0) ? mpu_pkg::ACT_INVERSE : mpu_pkg::ACT_POWER;
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = cur_mod;
      2: b = cur_mod - 1;
      3: begin
        mult = 64'(cur_mod) * 64'($urandom_range(2, 40));
        b = (mult > 64'h7FFF_FFFF) ? cur_mod : mult[mpu_pkg::MOD_W-1:0];
      end
      4: b = mpu_pkg::MOD_W'($urandom_range(0, 15));
      5: b = '1;
      default: b = mpu_pkg::MOD_W'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0: e = '0;
      1: e = 32'd1;
      2: e = '1;
      3: e = mpu_pkg::EXP_IN_W'($urandom_range(0, 63));
      4: e = 32'd1 << $urandom_range(0, 31);
      default: e = $urandom();
    endcase
    offer(act, b, e);
  endtask

  // Modulus for each random phase: extremes, primes, composites and random values.
  function automatic logic [mpu_pkg::MOD_W-1:0] pick_modulus(input int p);
    case (p)
      0:  return mpu_pkg::MOD_RESET;
      1:  return 31'h7FFF_FFFF;
      2:  return 31'd2;
      3:  return 31'd998244353;
      4:  return 31'd65537;
      5:  return mpu_pkg::MOD_W'($urandom_range(2, 1000));
      6:  return mpu_pkg::MOD_W'($urandom()) | 31'h4000_0000;
      7:  return mpu_pkg::MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
      8:  return 31'd3;
      9:  return mpu_pkg::MOD_W'($urandom_range(2, 65535));
      10: return 31'h7FFF_FFFE;
      default: return mpu_pkg::MOD_RESET;
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    action        = mpu_pkg::ACT_POWER;
    base          = '0;
    exponent      = '0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    long_hold_req = 1'b0;
    cur_mod       = mpu_pkg::MOD_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset modulus: zero exponent, extremes, inverse cases.
    offer(mpu_pkg::ACT_POWER,   31'd0,          32'd0);
    offer(mpu_pkg::ACT_POWER,   31'h7FFF_FFFF,  32'hFFFF_FFFF);
    offer(mpu_pkg::ACT_POWER,   31'd2,          32'd1);
    offer(mpu_pkg::ACT_INVERSE, 31'd2,          32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'd1000000007, 32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'd0,          32'hFFFF_FFFF);
    offer(mpu_pkg::ACT_POWER,   31'h7FFF_FFFF,  32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'h7FFF_FFFF,  32'h8000_0001);
    hold_inputs();

    // Largest modulus: a base equal to it reduces to zero.
    load_modulus(31'h7FFF_FFFF);
    offer(mpu_pkg::ACT_POWER,   31'h7FFF_FFFF,  32'd5);
    offer(mpu_pkg::ACT_INVERSE, 31'h7FFF_FFFE,  32'd0);
    offer(mpu_pkg::ACT_POWER,   31'd12345,      32'hFFFF_FFFF);
    hold_inputs();

    // Smallest modulus: the inverse uses exponent zero, so it gives one.
    load_modulus(31'd2);
    offer(mpu_pkg::ACT_INVERSE, 31'd0,          32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'd1,          32'd7);
    offer(mpu_pkg::ACT_POWER,   31'd3,          32'd7);
    offer(mpu_pkg::ACT_POWER,   31'd2,          32'd0);
    hold_inputs();

    // A modulus below two always gives zero.
    load_modulus(31'd0);
    offer(mpu_pkg::ACT_POWER,   31'd5,          32'd3);
    offer(mpu_pkg::ACT_INVERSE, 31'd7,          32'd0);
    hold_inputs();
    load_modulus(31'd1);
    offer(mpu_pkg::ACT_POWER,   31'd0,          32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'd9,          32'd1);
    hold_inputs();

    // Base divisible by a prime modulus has no inverse; a composite modulus still gets a power.
    load_modulus(31'd3);
    offer(mpu_pkg::ACT_INVERSE, 31'd3,          32'd0);
    offer(mpu_pkg::ACT_INVERSE, 31'd2,          32'd0);
    hold_inputs();
    load_modulus(31'd1000000);
    offer(mpu_pkg::ACT_INVERSE, 31'd3,          32'd0);
    hold_inputs();

    // Random phases, one modulus each; no idling in the last one.
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_modulus(pick_modulus(p));
      if (p == RAND_PHASES - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == PHASE_ITEMS / 2) begin
          hold_inputs();
          wait (pending == 0);
          @(posedge clk);
        end
        if (p == 1 && k == 10) long_hold_req = 1'b1;
        offer_random();
      end
      hold_inputs();
    end

    // Let every result drain, then watch a while for stray outputs.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mpu_pkg.sv
src/mpu_mulmod.sv
src/modular_power_unit_core.sv
dv/mpu_checker.sv
dv/tb.sv
